[src/assert_macros.svh]
// Assertion macros used by the allocator datapath
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef ASSERT_OFF
`define ASSERT_CLKD(lbl, prop, msg) lbl: assert property (@(posedge clk) disable iff (!rst_n) \
  prop) else $error(msg);
`define ASSERT_NEVER(lbl, cond, msg) `ASSERT_CLKD(lbl, !(cond), msg)
`else
`define ASSERT_CLKD(lbl, prop, msg)
`define ASSERT_NEVER(lbl, cond, msg)
`endif
`endif

[src/ffha_pkg.sv]
// Shared constants, codes and controller/datapath types for the heap allocator
`default_nettype none
package ffha_pkg;
  localparam int MAX_CHUNKS   = 64;
  localparam int IDX_W        = $clog2(MAX_CHUNKS);
  localparam int CNT_W        = IDX_W + 1;
  localparam int PAGE_BYTES   = 4096;
  localparam int PAGE_SHIFT   = $clog2(PAGE_BYTES);
  localparam int HEADER_BYTES = 16;

  localparam int ADDR_W     = 32;
  localparam int REQ_W      = 24;
  localparam int LEN_IN_W   = REQ_W + 1;
  localparam int LEN_W      = 32;
  localparam int OFF_W      = 33;
  localparam int LIM_W      = 17;
  localparam int PAGES_W    = 18;
  localparam int STATUS_W   = 2;
  localparam int CFG_IDX_W  = 1;
  localparam int CFG_DATA_W = 32;
  localparam int IN_TDATA_W  = 56;
  localparam int OUT_TDATA_W = 88;

  localparam logic [ADDR_W-1:0] HEAP_BASE_RST  = 32'hE000_0000;
  localparam logic [LIM_W-1:0]  PAGE_LIMIT_RST = 17'h10000;

  localparam logic [CFG_IDX_W-1:0] REG_HEAP_BASE  = 1'b0;
  localparam logic [CFG_IDX_W-1:0] REG_PAGE_LIMIT = 1'b1;

  localparam logic OPC_ALLOC = 1'b0;
  localparam logic OPC_FREE  = 1'b1;

  typedef enum logic [STATUS_W-1:0] {
    ST_OK           = 2'd0,
    ST_TABLE_FULL   = 2'd1,
    ST_PAGE_LIMIT   = 2'd2,
    ST_UNKNOWN_ADDR = 2'd3
  } status_t;

  typedef enum logic [4:0] {
    OP_NONE, OP_LOAD, OP_SCAN_RD, OP_SCAN_EV, OP_A_HIT, OP_SHU_RD, OP_SHU_WR,
    OP_WR_REST, OP_WR_HEAD, OP_A_NEED, OP_A_APPEND, OP_ERR_FULL, OP_ERR_UNKNOWN,
    OP_F_HIT, OP_FS_RD, OP_FS_EV, OP_FP_RD, OP_FP_EV, OP_SHD_INIT, OP_SHD_RD,
    OP_SHD_WR, OP_FIN_WR, OP_TAIL, OP_EMIT
  } dp_op_t;

  typedef struct packed {
    dp_op_t op;
  } dp_cmd_t;

  typedef struct packed {
    logic op_free;
    logic k_end;
    logic full;
    logic hit;
    logic do_split;
    logic has_next;
    logic k_nonzero;
    logic shu_more;
    logic shd_more;
    logic nrem_nz;
    logic out_free;
  } dp_stat_t;
endpackage
`default_nettype wire

[src/first_fit_heap_allocator.sv]
// Top level of the first-fit heap allocator with coalescing
//
// Input words carry one operation: tuser selects allocate or free, tdata holds
// the request size and the address to release. Each accepted word yields one
// result word with the payload address, a status code, the heap top after the
// operation and the signed number of pages mapped or released.
// Operations run one at a time. A word reads each table entry that it scans,
// reads and writes back each entry moved when a chunk is split or entries are
// merged away, and passes through bookkeeping states. Entries scanned and
// entries moved together never exceed the table size. The chunk table memory,
// accessed one entry at a time, sets the pace of these steps.
// A finished result waits in an output register while the next word is taken.
// If the receiver stalls with a result pending, the next result holds in the
// block until the register drains, and no further word is accepted meanwhile.
// Reset empties the chunk table and sets the heap top to the default base.
// Writing heap_base while idle empties the table the same way.
`default_nettype none
module first_fit_heap_allocator (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                cfg_wr_en,
  input  logic [ffha_pkg::CFG_IDX_W-1:0]      cfg_index,
  input  logic [ffha_pkg::CFG_DATA_W-1:0]     cfg_wdata,
  input  logic                                in_tvalid,
  output logic                                in_tready,
  // request_bytes, release_addr
  input  logic [ffha_pkg::IN_TDATA_W-1:0]     in_tdata,
  // op
  input  logic                                in_tuser,
  output logic                                out_tvalid,
  input  logic                                out_tready,
  // block_addr, status, heap_top, pages_changed
  output logic [ffha_pkg::OUT_TDATA_W-1:0]    out_tdata
);
  import ffha_pkg::*;

  dp_cmd_t             cmd;
  dp_stat_t            stat;
  logic [ADDR_W-1:0]   out_addr, out_top;
  logic [STATUS_W-1:0] out_status;
  logic [PAGES_W-1:0]  out_pages;

  ffha_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_tvalid),
    .in_ready (in_tready),
    .stat     (stat),
    .cmd      (cmd)
  );

  ffha_dp u_dp (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg_wr_en  (cfg_wr_en),
    .cfg_index  (cfg_index),
    .cfg_wdata  (cfg_wdata),
    .in_op      (in_tuser),
    .in_req     (in_tdata[REQ_W-1:0]),
    .in_addr    (in_tdata[REQ_W+ADDR_W-1:REQ_W]),
    .cmd        (cmd),
    .stat       (stat),
    .out_valid  (out_tvalid),
    .out_ready  (out_tready),
    .out_addr   (out_addr),
    .out_status (out_status),
    .out_top    (out_top),
    .out_pages  (out_pages)
  );

  assign out_tdata = {(OUT_TDATA_W - 2*ADDR_W - STATUS_W - PAGES_W)'(0),
                      out_pages, out_top, out_status, out_addr};
endmodule
`default_nettype wire

[src/ffha_ctrl.sv]
// Sequencer for scan, split, merge and shift steps of the heap allocator
`default_nettype none
module ffha_ctrl (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_ready,
  input  ffha_pkg::dp_stat_t stat,
  output ffha_pkg::dp_cmd_t  cmd
);
  import ffha_pkg::*;

  typedef enum logic [20:0] {
    S_IDLE     = 21'h000001,
    S_SCAN_RD  = 21'h000002,
    S_SCAN_EV  = 21'h000004,
    S_A_HIT    = 21'h000008,
    S_SHU_RD   = 21'h000010,
    S_SHU_WR   = 21'h000020,
    S_WR_REST  = 21'h000040,
    S_WR_HEAD  = 21'h000080,
    S_A_NEED   = 21'h000100,
    S_A_APPEND = 21'h000200,
    S_F_HIT    = 21'h000400,
    S_FS_RD    = 21'h000800,
    S_FS_EV    = 21'h001000,
    S_FP_RD    = 21'h002000,
    S_FP_EV    = 21'h004000,
    S_SHD_INIT = 21'h008000,
    S_SHD_RD   = 21'h010000,
    S_SHD_WR   = 21'h020000,
    S_FIN_WR   = 21'h040000,
    S_TAIL     = 21'h080000,
    S_EMIT     = 21'h100000
  } state_t;

  state_t state_r, state_nxt;

  assign in_ready = (state_r == S_IDLE);

  always_comb begin
    state_nxt = state_r;
    cmd.op    = OP_NONE;
    case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          cmd.op    = OP_LOAD;
          state_nxt = S_SCAN_RD;
        end
      end
      S_SCAN_RD: begin
        if (!stat.k_end) begin
          cmd.op    = OP_SCAN_RD;
          state_nxt = S_SCAN_EV;
        end else if (stat.op_free) begin
          cmd.op    = OP_ERR_UNKNOWN;
          state_nxt = S_EMIT;
        end else if (stat.full) begin
          cmd.op    = OP_ERR_FULL;
          state_nxt = S_EMIT;
        end else begin
          state_nxt = S_A_NEED;
        end
      end
      S_SCAN_EV: begin
        cmd.op = OP_SCAN_EV;
        if (stat.hit) begin
          state_nxt = stat.op_free ? S_F_HIT : S_A_HIT;
        end else begin
          state_nxt = S_SCAN_RD;
        end
      end
      S_A_HIT: begin
        cmd.op    = OP_A_HIT;
        state_nxt = stat.do_split ? S_SHU_RD : S_WR_HEAD;
      end
      S_SHU_RD: begin
        if (stat.shu_more) begin
          cmd.op    = OP_SHU_RD;
          state_nxt = S_SHU_WR;
        end else begin
          state_nxt = S_WR_REST;
        end
      end
      S_SHU_WR: begin
        cmd.op    = OP_SHU_WR;
        state_nxt = S_SHU_RD;
      end
      S_WR_REST: begin
        cmd.op    = OP_WR_REST;
        state_nxt = S_WR_HEAD;
      end
      S_WR_HEAD: begin
        cmd.op    = OP_WR_HEAD;
        state_nxt = S_EMIT;
      end
      S_A_NEED: begin
        cmd.op    = OP_A_NEED;
        state_nxt = S_A_APPEND;
      end
      S_A_APPEND: begin
        cmd.op    = OP_A_APPEND;
        state_nxt = S_EMIT;
      end
      S_F_HIT: begin
        cmd.op    = OP_F_HIT;
        state_nxt = S_FS_RD;
      end
      S_FS_RD: begin
        if (stat.has_next) begin
          cmd.op    = OP_FS_RD;
          state_nxt = S_FS_EV;
        end else begin
          state_nxt = S_FP_RD;
        end
      end
      S_FS_EV: begin
        cmd.op    = OP_FS_EV;
        state_nxt = S_FP_RD;
      end
      S_FP_RD: begin
        if (stat.k_nonzero) begin
          cmd.op    = OP_FP_RD;
          state_nxt = S_FP_EV;
        end else begin
          state_nxt = S_SHD_INIT;
        end
      end
      S_FP_EV: begin
        cmd.op    = OP_FP_EV;
        state_nxt = S_SHD_INIT;
      end
      S_SHD_INIT: begin
        cmd.op    = OP_SHD_INIT;
        state_nxt = S_SHD_RD;
      end
      S_SHD_RD: begin
        if (stat.nrem_nz && stat.shd_more) begin
          cmd.op    = OP_SHD_RD;
          state_nxt = S_SHD_WR;
        end else begin
          state_nxt = S_FIN_WR;
        end
      end
      S_SHD_WR: begin
        cmd.op    = OP_SHD_WR;
        state_nxt = S_SHD_RD;
      end
      S_FIN_WR: begin
        cmd.op    = OP_FIN_WR;
        state_nxt = S_TAIL;
      end
      S_TAIL: begin
        cmd.op    = OP_TAIL;
        state_nxt = S_EMIT;
      end
      S_EMIT: begin
        if (stat.out_free) begin
          cmd.op    = OP_EMIT;
          state_nxt = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end
endmodule
`default_nettype wire

[src/ffha_dp.sv]
// Chunk table memory, heap registers and arithmetic of the heap allocator
`default_nettype none
`include "assert_macros.svh"
module ffha_dp (
  input  logic                               clk,
  input  logic                               rst_n,
  input  logic                               cfg_wr_en,
  input  logic [ffha_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  logic [ffha_pkg::CFG_DATA_W-1:0]    cfg_wdata,
  input  logic                               in_op,
  input  logic [ffha_pkg::REQ_W-1:0]         in_req,
  input  logic [ffha_pkg::ADDR_W-1:0]        in_addr,
  input  ffha_pkg::dp_cmd_t                  cmd,
  output ffha_pkg::dp_stat_t                 stat,
  output logic                               out_valid,
  input  logic                               out_ready,
  output logic [ffha_pkg::ADDR_W-1:0]        out_addr,
  output logic [ffha_pkg::STATUS_W-1:0]      out_status,
  output logic [ffha_pkg::ADDR_W-1:0]        out_top,
  output logic [ffha_pkg::PAGES_W-1:0]       out_pages
);
  import ffha_pkg::*;

  localparam int SUM_W  = OFF_W + 1;
  localparam int NEED_W = SUM_W - PAGE_SHIFT;
  localparam int NP_W   = NEED_W + 1;
  localparam int NT_W   = SUM_W + 1;
  localparam int REL_W  = ADDR_W - PAGE_SHIFT;

  logic [LEN_W:0]   mem [MAX_CHUNKS];
  logic [LEN_W:0]   rd_q;
  logic             rd_en, wr_en;
  logic [IDX_W-1:0] rd_idx, wr_idx;
  logic [LEN_W:0]   wr_word;

  logic [ADDR_W-1:0]   base_r, top_r;
  logic [LIM_W-1:0]    limit_r;
  logic [CNT_W-1:0]    count_r, k_r, j_r;
  logic                out_valid_r;
  logic                op_r, split_r;
  logic [LEN_IN_W-1:0] len_r;
  logic [ADDR_W-1:0]   want_r;
  logic [OFF_W-1:0]    off_r;
  logic [LEN_W-1:0]    cur_len_r;
  logic [1:0]          nrem_r;
  logic [NEED_W-1:0]   need_r;
  logic [ADDR_W-1:0]   res_addr_r, out_addr_r, out_top_r;
  status_t             res_status_r;
  logic [STATUS_W-1:0] out_status_r;
  logic [PAGES_W-1:0]  res_pages_r, out_pages_r;

  logic [LEN_W-1:0]  rd_len, len_ext, rest;
  logic              rd_used;
  logic [CNT_W-1:0]  k_plus1, k_minus1, j_minus1, j_plus_n;
  logic [ADDR_W-1:0] top_off, pay_addr;
  logic              hit_alloc, hit_free;
  logic [SUM_W-1:0]  sum_a, diff_a;
  logic [NEED_W-1:0] need_nxt;
  logic [NP_W-1:0]   new_pages;
  logic [NT_W-1:0]   new_top;
  logic              pg_fail, tail;
  logic [ADDR_W-1:0] span;
  logic [REL_W-1:0]  released;

  assign rd_len   = rd_q[LEN_W:1];
  assign rd_used  = rd_q[0];
  assign len_ext  = LEN_W'(len_r);
  assign rest     = cur_len_r - len_ext;
  assign k_plus1  = k_r + 1'b1;
  assign k_minus1 = k_r - 1'b1;
  assign j_minus1 = j_r - 1'b1;
  assign j_plus_n = j_r + CNT_W'(nrem_r);
  assign top_off  = top_r - base_r;
  assign pay_addr = base_r + off_r[ADDR_W-1:0] + ADDR_W'(HEADER_BYTES);

  assign hit_alloc = !rd_used && (rd_len >= len_ext);
  assign hit_free  = rd_used && (pay_addr == want_r);

  assign sum_a    = SUM_W'(off_r) + SUM_W'(len_r);
  assign diff_a   = sum_a - SUM_W'(top_off) + SUM_W'(PAGE_BYTES - 1);
  assign need_nxt = (sum_a > SUM_W'(top_off)) ? diff_a[SUM_W-1:PAGE_SHIFT] : '0;

  assign new_pages = NP_W'(top_off[ADDR_W-1:PAGE_SHIFT]) + NP_W'(need_r);
  assign new_top   = NT_W'(top_off) + (NT_W'(need_r) << PAGE_SHIFT);
  assign pg_fail   = (new_pages > NP_W'(limit_r)) || (new_top[NT_W-1:ADDR_W] != '0);

  assign tail     = (k_plus1 == count_r);
  assign span     = (OFF_W'(top_off) >= off_r) ? (top_off - off_r[ADDR_W-1:0]) : '0;
  assign released = span[ADDR_W-1:PAGE_SHIFT];

  always_comb begin
    stat.op_free   = op_r;
    stat.k_end     = (k_r == count_r);
    stat.full      = (count_r >= CNT_W'(MAX_CHUNKS));
    stat.hit       = op_r ? hit_free : hit_alloc;
    stat.do_split  = ((rd_len - len_ext) > LEN_W'(HEADER_BYTES)) &&
                     (count_r < CNT_W'(MAX_CHUNKS));
    stat.has_next  = (k_plus1 < count_r);
    stat.k_nonzero = (k_r != '0);
    stat.shu_more  = (j_r > k_plus1);
    stat.shd_more  = (j_plus_n < count_r);
    stat.nrem_nz   = (nrem_r != 2'd0);
    stat.out_free  = !out_valid_r || out_ready;
  end

  always_comb begin
    rd_en   = 1'b0;
    rd_idx  = '0;
    wr_en   = 1'b0;
    wr_idx  = '0;
    wr_word = '0;
    case (cmd.op)
      OP_SCAN_RD: begin
        rd_en  = 1'b1;
        rd_idx = k_r[IDX_W-1:0];
      end
      OP_FS_RD: begin
        rd_en  = 1'b1;
        rd_idx = k_plus1[IDX_W-1:0];
      end
      OP_FP_RD: begin
        rd_en  = 1'b1;
        rd_idx = k_minus1[IDX_W-1:0];
      end
      OP_SHU_RD: begin
        rd_en  = 1'b1;
        rd_idx = j_minus1[IDX_W-1:0];
      end
      OP_SHD_RD: begin
        rd_en  = 1'b1;
        rd_idx = j_plus_n[IDX_W-1:0];
      end
      OP_SHU_WR, OP_SHD_WR: begin
        wr_en   = 1'b1;
        wr_idx  = j_r[IDX_W-1:0];
        wr_word = rd_q;
      end
      OP_WR_REST: begin
        wr_en   = 1'b1;
        wr_idx  = k_plus1[IDX_W-1:0];
        wr_word = {rest, 1'b0};
      end
      OP_WR_HEAD: begin
        wr_en   = 1'b1;
        wr_idx  = k_r[IDX_W-1:0];
        wr_word = {(split_r ? len_ext : cur_len_r), 1'b1};
      end
      OP_A_APPEND: begin
        wr_en   = !pg_fail;
        wr_idx  = count_r[IDX_W-1:0];
        wr_word = {len_ext, 1'b1};
      end
      OP_FIN_WR: begin
        wr_en   = 1'b1;
        wr_idx  = k_r[IDX_W-1:0];
        wr_word = {cur_len_r, 1'b0};
      end
      default: begin
        rd_en = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_idx] <= wr_word;
    end
    if (rd_en) begin
      rd_q <= mem[rd_idx];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      base_r      <= HEAP_BASE_RST;
      top_r       <= HEAP_BASE_RST;
      limit_r     <= PAGE_LIMIT_RST;
      count_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (cfg_wr_en) begin
        case (cfg_index)
          REG_HEAP_BASE: begin
            base_r  <= cfg_wdata;
            top_r   <= cfg_wdata;
            count_r <= '0;
          end
          REG_PAGE_LIMIT: begin
            limit_r <= cfg_wdata[LIM_W-1:0];
          end
          default: begin
            limit_r <= limit_r;
          end
        endcase
      end
      if (cmd.op == OP_EMIT) begin
        out_valid_r <= 1'b1;
      end else if (out_valid_r && out_ready) begin
        out_valid_r <= 1'b0;
      end
      case (cmd.op)
        OP_WR_HEAD: begin
          if (split_r) begin
            count_r <= count_r + 1'b1;
          end
        end
        OP_A_APPEND: begin
          if (!pg_fail) begin
            count_r <= count_r + 1'b1;
            top_r   <= base_r + new_top[ADDR_W-1:0];
          end
        end
        OP_FIN_WR: begin
          count_r <= count_r - CNT_W'(nrem_r);
        end
        OP_TAIL: begin
          if (tail) begin
            count_r <= k_r;
            top_r   <= top_r - {released, PAGE_SHIFT'(0)};
          end
        end
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    case (cmd.op)
      OP_LOAD: begin
        op_r         <= in_op;
        len_r        <= LEN_IN_W'(in_req) + LEN_IN_W'(HEADER_BYTES);
        want_r       <= in_addr;
        k_r          <= '0;
        off_r        <= '0;
        res_addr_r   <= '0;
        res_status_r <= ST_OK;
        res_pages_r  <= '0;
      end
      OP_SCAN_EV: begin
        if (!(op_r ? hit_free : hit_alloc)) begin
          off_r <= off_r + OFF_W'(rd_len);
          k_r   <= k_plus1;
        end
      end
      OP_A_HIT: begin
        cur_len_r <= rd_len;
        split_r   <= stat.do_split;
        j_r       <= count_r;
      end
      OP_SHU_WR: begin
        j_r <= j_minus1;
      end
      OP_WR_HEAD: begin
        res_addr_r <= pay_addr;
      end
      OP_A_NEED: begin
        need_r <= need_nxt;
      end
      OP_A_APPEND: begin
        if (pg_fail) begin
          res_status_r <= ST_PAGE_LIMIT;
        end else begin
          res_addr_r  <= pay_addr;
          res_pages_r <= PAGES_W'(need_r);
        end
      end
      OP_ERR_FULL: begin
        res_status_r <= ST_TABLE_FULL;
      end
      OP_ERR_UNKNOWN: begin
        res_status_r <= ST_UNKNOWN_ADDR;
      end
      OP_F_HIT: begin
        cur_len_r <= rd_len;
        nrem_r    <= 2'd0;
      end
      OP_FS_EV: begin
        if (!rd_used) begin
          cur_len_r <= cur_len_r + rd_len;
          nrem_r    <= 2'd1;
        end
      end
      OP_FP_EV: begin
        if (!rd_used) begin
          cur_len_r <= cur_len_r + rd_len;
          off_r     <= off_r - OFF_W'(rd_len);
          k_r       <= k_minus1;
          nrem_r    <= nrem_r + 2'd1;
        end
      end
      OP_SHD_INIT: begin
        j_r <= k_plus1;
      end
      OP_SHD_WR: begin
        j_r <= j_r + 1'b1;
      end
      OP_TAIL: begin
        if (tail) begin
          res_pages_r <= -PAGES_W'(released);
        end
      end
      OP_EMIT: begin
        out_addr_r   <= res_addr_r;
        out_status_r <= res_status_r;
        out_top_r    <= top_r;
        out_pages_r  <= res_pages_r;
      end
      default: begin
        op_r <= op_r;
      end
    endcase
  end

  assign out_valid  = out_valid_r;
  assign out_addr   = out_addr_r;
  assign out_status = out_status_r;
  assign out_top    = out_top_r;
  assign out_pages  = out_pages_r;

  `ASSERT_CLKD(a_count_range, count_r <= CNT_W'(MAX_CHUNKS), "chunk count above table size")
  `ASSERT_CLKD(a_top_paged, top_off[PAGE_SHIFT-1:0] == '0, "heap top off page grid")
  `ASSERT_CLKD(a_emit_free, (cmd.op == OP_EMIT) |-> stat.out_free, "result overwrites pending word")
  `ASSERT_CLKD(a_shift_range, (cmd.op == OP_SHU_WR) |-> (j_r <= count_r), "shift beyond table")
endmodule
`default_nettype wire
